// ===== hdl/pgfk_pkg.sv =====
package pgfk_pkg;

	// Field widths
	localparam int unsigned PITCH_W    = 13;
	localparam int unsigned STEP_W     = 8;
	localparam int unsigned ADJ_W      = 13;
	localparam int unsigned KEY_W      = 7;
	localparam int unsigned FRAC_W     = 8;
	localparam int unsigned IDX_W      = 7;
	localparam int unsigned PNUM_W     = 15;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 16;

	// Pitch-to-note constants
	localparam int unsigned NOTE_TABLE_DEPTH = 96;
	localparam int unsigned NOTE_OFFSET      = 64;
	localparam logic [FRAC_W-1:0] FRACTION_MAX = 8'hFC;

	typedef logic [PITCH_W-1:0] pitch_t;
	typedef logic [STEP_W-1:0]  step_t;
	typedef logic signed [ADJ_W-1:0] adjust_t;
	typedef logic [IDX_W-1:0]   note_idx_t;

	typedef struct packed {
		logic [FRAC_W-1:0] key_fraction;
		logic [KEY_W-1:0]  key_code;
	} key_t;

	// Key code skips every fourth value: idx + idx/3.
	// idx/3 as (idx * 43) >> 7, exact for idx below 128.
	function automatic logic [KEY_W-1:0] key_code_of(input note_idx_t idx);
		logic [IDX_W+5:0] prod;
		logic [KEY_W-1:0] third;
		prod  = {6'd0, idx} * 13'd43;
		third = {1'b0, prod[IDX_W+5:7]};
		return idx + third;
	endfunction

endpackage

// ===== hdl/pitch_glide_to_fm_keycode_top.sv =====
// Channel   | Ports                     | Contents (lowest bit up)
// ----------+---------------------------+-----------------------------------------
// input     | s_axis_tvalid/tready/tdata | goal_pitch[12:0], glide_step[20:13]
// result    | m_axis_tvalid/tready/tdata | key_code[6:0], key_fraction[14:7]
// config    | cfg_valid/cfg_ready/cfg_data | clock_adjust (signed, 13 bits)
//
// One item per cycle sustained while the result is not stalled.
// The glide update of the current pitch and the key mapping sit between the input
// register and the result register; the current pitch register closes the item loop.
// arst_n clears the valids, the current pitch and clock_adjust.
// A stalled result holds while the input register still takes one more item.
module pitch_glide_to_fm_keycode_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // goal_pitch[12:0], glide_step[20:13], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // key_code[6:0], key_fraction[14:7], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data        // clock_adjust
);

	logic                 in_v_s1;
	pgfk_pkg::pitch_t     tgt_s1;
	pgfk_pkg::step_t      step_s1;
	logic                 out_v_s2;
	pgfk_pkg::key_t       key_s2;
	pgfk_pkg::pitch_t     cur_pitch_q;
	pgfk_pkg::adjust_t    clock_adjust_q;
	pgfk_pkg::pitch_t     nxt_pitch;
	pgfk_pkg::key_t       key_nxt;
	logic [pgfk_pkg::PITCH_W:0] sum;
	logic [pgfk_pkg::PITCH_W:0] diff;
	logic [pgfk_pkg::PITCH_W:0] tgt_ext;
	logic                 adv_s1;

	// Handshake
	assign adv_s1        = in_v_s1 && (!out_v_s2 || m_axis_tready);
	assign s_axis_tready = !in_v_s1 || adv_s1;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_v_s2;
	assign m_axis_tdata  = {1'b0, key_s2};

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_adjust_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			clock_adjust_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tgt_s1  <= s_axis_tdata[12:0];
			step_s1 <= s_axis_tdata[20:13];
		end
	end

	// Glide toward target, stop on it; zero step jumps
	always_comb begin
		sum     = {1'b0, cur_pitch_q} + {6'd0, step_s1};
		diff    = {1'b0, cur_pitch_q} - {6'd0, step_s1};
		tgt_ext = {1'b0, tgt_s1};
		if (step_s1 == '0) begin
			nxt_pitch = tgt_s1;
		end else if (cur_pitch_q < tgt_s1) begin
			nxt_pitch = (sum > tgt_ext) ? tgt_s1 : sum[pgfk_pkg::PITCH_W-1:0];
		end else if (cur_pitch_q > tgt_s1) begin
			nxt_pitch = (diff[pgfk_pkg::PITCH_W] || diff < tgt_ext) ? tgt_s1
				: diff[pgfk_pkg::PITCH_W-1:0];
		end else begin
			nxt_pitch = cur_pitch_q;
		end
	end

	pgfk_keymap u_keymap (
		.pitch        (nxt_pitch),
		.clock_adjust (clock_adjust_q),
		.key          (key_nxt)
	);

	// Advance current pitch and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pitch_q <= '0;
			out_v_s2    <= 1'b0;
		end else begin
			if (adv_s1) begin
				cur_pitch_q <= nxt_pitch;
				out_v_s2    <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_s2    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			key_s2 <= key_nxt;
		end
	end

endmodule

// ===== hdl/pgfk_keymap.sv =====
module pgfk_keymap (
	input  pgfk_pkg::pitch_t  pitch,
	input  pgfk_pkg::adjust_t clock_adjust,
	output pgfk_pkg::key_t    key
);

	logic signed [pgfk_pkg::PNUM_W-1:0] pnum;
	logic [pgfk_pkg::PNUM_W-2:0]        pos;
	logic [7:0]                         idx_raw;
	pgfk_pkg::note_idx_t                idx;
	logic [pgfk_pkg::FRAC_W-1:0]        frac;

	// Offset pitch by clock adjust and note base, floor at zero
	always_comb begin
		pnum = $signed({2'b00, pitch}) + $signed({{2{clock_adjust[pgfk_pkg::ADJ_W-1]}},
			clock_adjust}) - $signed(15'(pgfk_pkg::NOTE_OFFSET));
		pos  = pnum[pgfk_pkg::PNUM_W-1] ? '0 : pnum[pgfk_pkg::PNUM_W-2:0];
	end

	// Split into note index and fraction, clamp index to table depth
	always_comb begin
		idx_raw = pos[13:6];
		if (idx_raw >= 8'(pgfk_pkg::NOTE_TABLE_DEPTH)) begin
			idx  = 7'(pgfk_pkg::NOTE_TABLE_DEPTH - 1);
			frac = pgfk_pkg::FRACTION_MAX;
		end else begin
			idx  = idx_raw[6:0];
			frac = {pos[5:0], 2'b00};
		end
		key.key_code     = pgfk_pkg::key_code_of(idx);
		key.key_fraction = frac;
	end

endmodule

// ===== hdl/pgfk_chk.sv =====
module pgfk_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Every input transfer is followed by a valid result
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
		else $error("result missing after input transfer");

	// Key code skips every fourth value and stays in range
	a_key: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b11 && m_axis_tdata[6:0] != 7'd127)
		else $error("key code out of set");

	// Fraction is a multiple of four and the pad bit is zero
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[8:7] == 2'b00 && m_axis_tdata[15] == 1'b0)
		else $error("fraction low bits set");

endmodule

bind pitch_glide_to_fm_keycode_top pgfk_chk u_pgfk_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
